>>> hw/rtl/sht1x_mc_pkg.sv
// Shared types and constants for the two-wire sensor measurement controller.
// Holds the register map, reset values and the structs passed between modules.
// No dependencies.
package sht1x_mc_pkg;

  // Default structural parameters
  localparam int DefResetClocks = 9;
  localparam int DefCountWidth  = 24;

  // Configuration register map
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_HALF_PERIOD   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_POLLS     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SETTLE        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_CMD       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_CMD      = 3'd5;

  // Register reset values
  localparam logic [7:0]  RST_HALF_PERIOD   = 8'd5;
  localparam logic [23:0] RST_POLL_INTERVAL = 24'd100000;
  localparam logic [7:0]  RST_MAX_POLLS     = 8'd20;
  localparam logic [23:0] RST_SETTLE        = 24'd200000;
  localparam logic [7:0]  RST_HUM_CMD       = 8'h05;
  localparam logic [7:0]  RST_TEMP_CMD      = 8'h03;

  // Stream word widths
  localparam int InDataW  = 8;
  localparam int OutDataW = 40;

  typedef struct packed {
    logic [7:0]  half_period;
    logic [23:0] poll_interval;
    logic [7:0]  max_polls;
    logic [23:0] settle;
    logic [7:0]  hum_cmd;
    logic [7:0]  temp_cmd;
  } cfg_t;

  typedef struct packed {
    logic        temperature_error;
    logic        humidity_error;
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        done;
    logic        busy;
    logic        data_drive;
    logic        data_out;
    logic        clock_out;
  } res_t;

endpackage

>>> hw/rtl/sht1x_mc_seq.sv
// Pin-level sequencer: measurement state, tick counters and line levels.
// Advances one tick per accepted word. Depends on sht1x_mc_pkg.
module sht1x_mc_seq #(
  parameter int ResetClocks = sht1x_mc_pkg::DefResetClocks,
  parameter int CountWidth  = sht1x_mc_pkg::DefCountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                start_i,
  input  logic                data_i,
  input  sht1x_mc_pkg::cfg_t  cfg_i,
  output sht1x_mc_pkg::res_t  res_o
);

  // Phase codes
  localparam logic [4:0] P_IDLE     = 5'd0;
  localparam logic [4:0] P_RST_HIGH = 5'd1;
  localparam logic [4:0] P_RST_LOW  = 5'd2;
  localparam logic [4:0] P_ST_A     = 5'd3;
  localparam logic [4:0] P_ST_B     = 5'd4;
  localparam logic [4:0] P_ST_C     = 5'd5;
  localparam logic [4:0] P_ST_D     = 5'd6;
  localparam logic [4:0] P_ST_E     = 5'd7;
  localparam logic [4:0] P_ST_F     = 5'd8;
  localparam logic [4:0] P_WR_LOW   = 5'd9;
  localparam logic [4:0] P_WR_HIGH  = 5'd10;
  localparam logic [4:0] P_WA_LOW   = 5'd11;
  localparam logic [4:0] P_WA_HIGH  = 5'd12;
  localparam logic [4:0] P_POLL     = 5'd13;
  localparam logic [4:0] P_RD_LOW   = 5'd14;
  localparam logic [4:0] P_RD_HIGH  = 5'd15;
  localparam logic [4:0] P_RA_LOW   = 5'd16;
  localparam logic [4:0] P_RA_HIGH  = 5'd17;
  localparam logic [4:0] P_SETTLE   = 5'd18;

  localparam logic [32:0] CountMax = (33'd1 << CountWidth) - 33'd1;
  localparam logic [3:0]  ResetClocksC = 4'(ResetClocks);
  localparam logic [1:0]  RecoveryIdx = 2'd3;

  // Clamp a threshold to the counter range
  function automatic logic [CountWidth-1:0] sat_count(input logic [23:0] v);
    logic [32:0] v_ext;
    v_ext = {9'd0, v};
    if (v_ext > CountMax) begin
      sat_count = CountMax[CountWidth-1:0];
    end else begin
      sat_count = v_ext[CountWidth-1:0];
    end
  endfunction

  logic [4:0]            phase_q, phase_d;
  logic [CountWidth-1:0] tick_q, tick_d;
  logic [3:0]            bit_q, bit_d;
  logic [1:0]            byte_q, byte_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            poll_q, poll_d;
  logic                  meas_temp_q, meas_temp_d;
  logic [15:0]           hum_q, hum_d;
  logic [15:0]           temp_q, temp_d;
  logic [1:0]            err_q, err_d;

  logic                  done;
  logic [CountWidth-1:0] tick_inc, hp_sat, poll_sat, poll_tick;
  logic                  held;
  logic [3:0]            bit_inc;
  logic [7:0]            poll_inc, max_eff;
  logic                  clk_lvl, dat_lvl, drv_lvl;

  assign tick_inc = tick_q + 1'b1;
  assign hp_sat   = sat_count({16'd0, (cfg_i.half_period == 8'd0) ? 8'd1 : cfg_i.half_period});
  assign poll_sat = sat_count((cfg_i.poll_interval == 24'd0) ? 24'd1 : cfg_i.poll_interval);
  assign held     = tick_inc >= hp_sat;
  assign bit_inc  = bit_q + 4'd1;
  assign poll_inc = poll_q + 8'd1;
  assign max_eff  = (cfg_i.max_polls == 8'd0) ? 8'd1 : cfg_i.max_polls;
  assign poll_tick = (tick_q == '0) ? CountWidth'(1) : tick_inc;

  // Next state for one tick
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    byte_d      = byte_q;
    shift_d     = shift_q;
    poll_d      = poll_q;
    meas_temp_d = meas_temp_q;
    hum_d       = hum_q;
    temp_d      = temp_q;
    err_d       = err_q;
    done        = 1'b0;

    unique case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          meas_temp_d = 1'b0;
          err_d       = 2'b00;
          phase_d     = P_RST_HIGH;
          tick_d      = '0;
          bit_d       = '0;
          byte_d      = '0;
        end
      end
      P_RST_HIGH, P_WR_LOW, P_WA_LOW, P_RD_LOW, P_RA_LOW: begin
        // plain held phase: step to the next phase of its pair
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          phase_d = phase_q + 5'd1;
        end
      end
      P_RST_LOW: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          if (bit_inc >= ResetClocksC) begin
            bit_d   = '0;
            phase_d = P_ST_A;
          end else begin
            bit_d   = bit_inc;
            phase_d = P_RST_HIGH;
          end
        end
      end
      P_ST_A, P_ST_B, P_ST_C, P_ST_D, P_ST_E: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          phase_d = phase_q + 5'd1;
        end
      end
      P_ST_F: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          if (byte_q == RecoveryIdx) begin
            // recovery reset done: close this measurement
            byte_d = '0;
            tick_d = '0;
            if (!meas_temp_q) begin
              meas_temp_d = 1'b1;
              phase_d     = P_SETTLE;
            end else begin
              meas_temp_d = 1'b0;
              phase_d     = P_IDLE;
              done        = 1'b1;
            end
          end else begin
            shift_d = meas_temp_q ? cfg_i.temp_cmd : cfg_i.hum_cmd;
            bit_d   = '0;
            phase_d = P_WR_LOW;
          end
        end
      end
      P_WR_HIGH: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            phase_d = P_WA_LOW;
          end else begin
            bit_d   = bit_inc;
            phase_d = P_WR_LOW;
          end
        end
      end
      P_WA_HIGH: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          if (data_i) begin
            // no acknowledge: flag, zero value, send recovery reset
            if (meas_temp_q) begin
              temp_d   = '0;
              err_d[1] = 1'b1;
            end else begin
              hum_d    = '0;
              err_d[0] = 1'b1;
            end
            phase_d = P_RST_HIGH;
            tick_d  = '0;
            bit_d   = '0;
            byte_d  = RecoveryIdx;
          end else begin
            phase_d = P_POLL;
            tick_d  = '0;
            poll_d  = '0;
          end
        end
      end
      P_POLL: begin
        if (tick_q == '0 && !data_i) begin
          // conversion finished: start reading
          phase_d = P_RD_LOW;
          tick_d  = '0;
          bit_d   = '0;
          byte_d  = '0;
          shift_d = '0;
        end else if (poll_tick >= poll_sat) begin
          tick_d = '0;
          poll_d = poll_inc;
          if (poll_inc >= max_eff) begin
            // timeout: flag, zero value, close measurement
            if (meas_temp_q) begin
              temp_d   = '0;
              err_d[1] = 1'b1;
              meas_temp_d = 1'b0;
              phase_d     = P_IDLE;
              done        = 1'b1;
            end else begin
              hum_d    = '0;
              err_d[0] = 1'b1;
              meas_temp_d = 1'b1;
              phase_d     = P_SETTLE;
            end
          end
        end else begin
          tick_d = poll_tick;
        end
      end
      P_RD_HIGH: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          shift_d = {shift_q[6:0], data_i};
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            phase_d = P_RA_LOW;
          end else begin
            bit_d   = bit_inc;
            phase_d = P_RD_LOW;
          end
        end
      end
      P_RA_HIGH: begin
        tick_d = held ? '0 : tick_inc;
        if (held) begin
          // store MSB then LSB; checksum byte is dropped
          if (byte_q == 2'd0) begin
            if (meas_temp_q) temp_d = {shift_q, 8'h00};
            else             hum_d  = {shift_q, 8'h00};
          end else if (byte_q == 2'd1) begin
            if (meas_temp_q) temp_d = {temp_q[15:8], shift_q};
            else             hum_d  = {hum_q[15:8], shift_q};
          end
          if (byte_q >= 2'd2) begin
            byte_d = '0;
            tick_d = '0;
            if (!meas_temp_q) begin
              meas_temp_d = 1'b1;
              phase_d     = P_SETTLE;
            end else begin
              meas_temp_d = 1'b0;
              phase_d     = P_IDLE;
              done        = 1'b1;
            end
          end else begin
            byte_d  = byte_q + 2'd1;
            shift_d = '0;
            phase_d = P_RD_LOW;
          end
        end
      end
      P_SETTLE: begin
        if (tick_q >= sat_count(cfg_i.settle)) begin
          phase_d = P_RST_HIGH;
          tick_d  = '0;
          bit_d   = '0;
          byte_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        phase_d = P_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // Line levels of the phase being entered
  always_comb begin
    clk_lvl = 1'b0;
    dat_lvl = 1'b0;
    drv_lvl = 1'b0;
    unique case (phase_d)
      P_RST_HIGH, P_ST_A, P_ST_E: begin
        clk_lvl = 1'b1; dat_lvl = 1'b1; drv_lvl = 1'b1;
      end
      P_RST_LOW, P_ST_F: begin
        dat_lvl = 1'b1; drv_lvl = 1'b1;
      end
      P_ST_B, P_ST_D: begin
        clk_lvl = 1'b1; drv_lvl = 1'b1;
      end
      P_ST_C: begin
        drv_lvl = 1'b1;
      end
      P_WR_LOW: begin
        dat_lvl = shift_d[7]; drv_lvl = 1'b1;
      end
      P_WR_HIGH: begin
        clk_lvl = 1'b1; dat_lvl = shift_d[7]; drv_lvl = 1'b1;
      end
      P_WA_HIGH, P_RD_HIGH: begin
        clk_lvl = 1'b1;
      end
      P_RA_LOW: begin
        dat_lvl = byte_d >= 2'd2; drv_lvl = 1'b1;
      end
      P_RA_HIGH: begin
        clk_lvl = 1'b1; dat_lvl = byte_d >= 2'd2; drv_lvl = 1'b1;
      end
      default: begin
        clk_lvl = 1'b0;
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res_o.clock_out         = clk_lvl;
    res_o.data_out          = dat_lvl;
    res_o.data_drive        = drv_lvl;
    res_o.busy              = phase_d != P_IDLE;
    res_o.done              = done;
    res_o.humidity_raw      = hum_d;
    res_o.temperature_raw   = temp_d;
    res_o.humidity_error    = err_d[0];
    res_o.temperature_error = err_d[1];
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      byte_q      <= '0;
      shift_q     <= '0;
      poll_q      <= '0;
      meas_temp_q <= 1'b0;
      hum_q       <= '0;
      temp_q      <= '0;
      err_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      byte_q      <= byte_d;
      shift_q     <= shift_d;
      poll_q      <= poll_d;
      meas_temp_q <= meas_temp_d;
      hum_q       <= hum_d;
      temp_q      <= temp_d;
      err_q       <= err_d;
    end
  end

  // Idle holds without a start request
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == P_IDLE && !start_i) |=> (phase_q == P_IDLE))
    else $error("sequencer left idle without a start request");

  // Every phase change restarts the tick counter
  a_tick_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_d != phase_q) |=> (tick_q == '0))
    else $error("tick counter not cleared on phase change");

  // Reset pulse count stays below its limit
  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_RST_HIGH || phase_q == P_RST_LOW) |-> (bit_q < ResetClocksC))
    else $error("reset pulse count out of range");

endmodule

>>> hw/rtl/sht1x_measurement_controller_top.sv
// Top level of the two-wire humidity/temperature sensor measurement controller.
// Holds the configuration registers, the stream handshake and the result
// register. Depends on sht1x_mc_pkg and sht1x_mc_seq.
//
// Usage: every word on the input stream is one tick of the sensor bus.
// Input tdata carries the start request and the sampled data line level;
// each accepted word produces exactly one output word with the clock line,
// data line drive level and enable, busy and done flags, the two raw readings
// and their error flags. A start while idle runs a humidity and then a
// temperature measurement; done pulses in the word where both are updated.
// The output word of an accepted input word is registered. One word is taken
// every cycle while the receiver keeps up: the sequencer updates its state
// in the accepting cycle and the output register holds the result. When the
// receiver stalls, the output word holds and the input side takes one more
// word only once the held word is taken. After reset the sequencer is idle,
// the readings and errors are zero and the registers hold their defaults.
// Configuration writes on the cfg channel are always taken;
// indexes past the register list are ignored.
module sht1x_measurement_controller_top #(
  parameter int ResetClocks = sht1x_mc_pkg::DefResetClocks,
  parameter int CountWidth  = sht1x_mc_pkg::DefCountWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // bit 0 start_request, bit 1 data_in, bits 7:2 zero
  input  logic [sht1x_mc_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // bit 0 clock_out, 1 data_out, 2 data_drive, 3 busy_res, 4 done_res,
  // 20:5 humidity_raw, 36:21 temperature_raw, 37 humidity_error,
  // 38 temperature_error, 39 zero
  output logic [sht1x_mc_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sht1x_mc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sht1x_mc_pkg::CfgDataW-1:0]   cfg_data_i
);

  sht1x_mc_pkg::cfg_t cfg_q;
  sht1x_mc_pkg::res_t res, res_q;
  logic               out_valid_q, out_valid_d;
  logic               accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period   <= sht1x_mc_pkg::RST_HALF_PERIOD;
      cfg_q.poll_interval <= sht1x_mc_pkg::RST_POLL_INTERVAL;
      cfg_q.max_polls     <= sht1x_mc_pkg::RST_MAX_POLLS;
      cfg_q.settle        <= sht1x_mc_pkg::RST_SETTLE;
      cfg_q.hum_cmd       <= sht1x_mc_pkg::RST_HUM_CMD;
      cfg_q.temp_cmd      <= sht1x_mc_pkg::RST_TEMP_CMD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sht1x_mc_pkg::REG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data_i[7:0];
        sht1x_mc_pkg::REG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data_i;
        sht1x_mc_pkg::REG_MAX_POLLS:     cfg_q.max_polls     <= cfg_data_i[7:0];
        sht1x_mc_pkg::REG_SETTLE:        cfg_q.settle        <= cfg_data_i;
        sht1x_mc_pkg::REG_HUM_CMD:       cfg_q.hum_cmd       <= cfg_data_i[7:0];
        sht1x_mc_pkg::REG_TEMP_CMD:      cfg_q.temp_cmd      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sht1x_mc_seq #(
    .ResetClocks (ResetClocks),
    .CountWidth  (CountWidth)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .start_i (s_axis_tdata_i[0]),
    .data_i  (s_axis_tdata_i[1]),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // Output word valid: set on accept, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q.temperature_error, res_q.humidity_error,
                            res_q.temperature_raw, res_q.humidity_raw, res_q.done,
                            res_q.busy, res_q.data_drive, res_q.data_out,
                            res_q.clock_out};

  // Done marks the end of the cycle, so the sequencer is idle then
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done) |-> !res_q.busy)
    else $error("done reported while still busy");

  // A released data line carries no driven level
  a_release_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.data_drive) |-> !res_q.data_out)
    else $error("data level set while line released");

  // The clock line only toggles during a measurement
  a_clock_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.clock_out) |-> res_q.busy)
    else $error("clock high while idle");

endmodule
